// ----- hw/rtl/cba_pkg.sv -----
// Package for the caching block allocator: opcodes, sizes, controller commands.
// No dependencies.
package cba_pkg;
   localparam int SlotCountDefault  = 1024;
   localparam int CacheDepthDefault = 64;
   localparam int HandleBitsDefault = 48;
   localparam int SlotW             = 10;
   localparam int SizeW             = 32;
   localparam int HandleW           = 48;

   typedef enum logic [1:0] {
      OP_REQ_SLOT = 2'd0,
      OP_ALLOC    = 2'd1,
      OP_REALLOC  = 2'd2,
      OP_RELEASE  = 2'd3
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch input item, read slot capacity
      logic search;    // find first fit, commit result, load result register
   } cmd_type;
endpackage

// ----- hw/rtl/cba_datapath.sv -----
// Datapath: slot pool, free stack, capacity memory and the sorted cache cells.
// Depends on cba_pkg.
module cba_datapath import cba_pkg::*; #(
   parameter int SLOT_COUNT  = SlotCountDefault,
   parameter int CACHE_DEPTH = CacheDepthDefault,
   parameter int HANDLE_BITS = HandleBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic [1:0]           in_opcode,
   input  logic [SlotW-1:0]     in_slot,
   input  logic [SizeW-1:0]     in_size,
   input  logic [HandleW-1:0]   in_handle,
   output logic [SlotW-1:0]     o_granted,
   output logic                 o_full,
   output logic                 o_hit,
   output logic [HandleW-1:0]   o_rhandle,
   output logic [SizeW-1:0]     o_rcap,
   output logic                 o_drop,
   output logic [HandleW-1:0]   o_dhandle
);
   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(CACHE_DEPTH);
   localparam int MIN_HB = (HANDLE_BITS < HandleW) ? HANDLE_BITS : HandleW;

   logic [SizeW-1:0]       cap_mem [SLOT_COUNT];
   logic [SW-1:0]          stk_mem [SLOT_COUNT];
   logic [SizeW-1:0]       rd_cap_ff;
   logic [SW-1:0]          rd_stk_ff;

   logic [SW:0]            used_ff, used_in;
   logic [SW:0]            top_ff, top_in;
   logic [CW:0]            cnt_ff, cnt_in;
   logic [HANDLE_BITS-1:0] ch_ff [CACHE_DEPTH];
   logic [SizeW-1:0]       cc_ff [CACHE_DEPTH];

   logic [1:0]             op_ff;
   logic [SW-1:0]          slot_ff;
   logic                   slot_ok_ff;
   logic [SizeW-1:0]       size_ff;
   logic [HANDLE_BITS-1:0] h_ff;

   logic [SlotW-1:0]       granted_ff;
   logic                   full_ff, hit_ff, drop_ff;
   logic [HandleW-1:0]     rh_ff, dh_ff;
   logic [SizeW-1:0]       rcap_ff;

   // Input capture and memory reads
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= in_opcode;
         slot_ff    <= in_slot[SW-1:0];
         slot_ok_ff <= (32'(in_slot) < 32'(used_ff))
                       && ({1'b0, in_slot} < (SlotW+1)'(SLOT_COUNT));
         size_ff    <= in_size;
         h_ff       <= HANDLE_BITS'(in_handle);
         rd_cap_ff  <= cap_mem[in_slot[SW-1:0]];
         rd_stk_ff  <= stk_mem[SW'(top_ff - 1'b1)];
      end
   end

   // Per-cell compare: fit and insert positions
   logic [CACHE_DEPTH-1:0] valid, fit, le_ins;
   logic [SizeW-1:0]       ins_cap;
   logic                   do_ins_rel, do_ins_rea;
   always_comb begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         valid[i]  = (CW+1)'(i) < cnt_ff;
         fit[i]    = valid[i] && (cc_ff[i] >= size_ff);
      end
   end

   // first fit index (priority)
   logic [CW-1:0] fidx;
   logic          fany;
   always_comb begin
      fidx = '0;
      fany = 1'b0;
      for (int i = CACHE_DEPTH-1; i >= 0; i--)
         if (fit[i]) begin
            fidx = CW'(i);
            fany = 1'b1;
         end
   end

   wire is_alloc   = op_ff == OP_ALLOC;
   wire is_realloc = op_ff == OP_REALLOC;
   wire is_rel     = op_ff == OP_RELEASE;
   wire hit_now    = slot_ok_ff && ((is_alloc && size_ff != '0) || is_realloc) && fany;
   assign ins_cap    = rd_cap_ff;
   assign do_ins_rel = slot_ok_ff && is_rel;
   assign do_ins_rea = hit_now && is_realloc && rd_cap_ff != '0;
   wire do_ins     = do_ins_rel || do_ins_rea;

   // cache list after removal (view): on a hit, cell i holds entry i+1 if i>=fidx, else entry i
   logic [HANDLE_BITS-1:0] vh [CACHE_DEPTH];
   logic [SizeW-1:0]       vc [CACHE_DEPTH];
   logic [CW:0]            vcnt;
   always_comb begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         if (hit_now && CW'(i) >= fidx && i < CACHE_DEPTH-1) begin
            vh[i] = ch_ff[i+1];
            vc[i] = cc_ff[i+1];
         end else begin
            vh[i] = ch_ff[i];
            vc[i] = cc_ff[i];
         end
      end
      vcnt = hit_now ? cnt_ff - 1'b1 : cnt_ff;
      for (int i = 0; i < CACHE_DEPTH; i++)
         le_ins[i] = ((CW+1)'(i) < vcnt) && (vc[i] <= ins_cap);
   end
   wire room = vcnt < (CW+1)'(CACHE_DEPTH);

   // insert position: count of entries with capacity <= ins_cap (list sorted)
   logic [CW:0] pos;
   always_comb begin
      pos = '0;
      for (int i = 0; i < CACHE_DEPTH; i++)
         if (le_ins[i]) pos = (CW+1)'(i + 1);
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (do_ins && room) begin
               if ((CW+1)'(i) == pos) begin
                  ch_ff[i] <= h_ff;
                  cc_ff[i] <= ins_cap;
               end else if ((CW+1)'(i) > pos && i > 0) begin
                  ch_ff[i] <= vh[i-1];
                  cc_ff[i] <= vc[i-1];
               end else begin
                  ch_ff[i] <= vh[i];
                  cc_ff[i] <= vc[i];
               end
            end else begin
               ch_ff[i] <= vh[i];
               cc_ff[i] <= vc[i];
            end
         end
      end
   end

   // Counters
   wire rq       = op_ff == OP_REQ_SLOT;
   wire pop      = rq && top_ff != '0;
   wire take_new = rq && !pop && used_ff < (SW+1)'(SLOT_COUNT);
   wire push     = do_ins_rel && top_ff < (SW+1)'(SLOT_COUNT);
   always_comb begin
      used_in = used_ff;
      top_in  = top_ff;
      cnt_in  = cnt_ff;
      if (cmd.search) begin
         if (take_new) used_in = used_ff + 1'b1;
         if (pop)      top_in  = top_ff - 1'b1;
         if (push)     top_in  = top_ff + 1'b1;
         cnt_in = (do_ins && room) ? vcnt + 1'b1 : vcnt;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         top_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         used_ff <= used_in;
         top_ff  <= top_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Slot capacity and stack writes, result register
   logic [SW-1:0]    gslot;
   logic [SizeW-1:0] new_cap;
   logic             cap_we;
   always_comb begin
      gslot   = pop ? rd_stk_ff : used_ff[SW-1:0];
      cap_we  = 1'b0;
      new_cap = rd_cap_ff;
      if (slot_ok_ff && (is_alloc || is_realloc)) begin
         if (hit_now) begin
            new_cap = cc_ff[fidx];
            cap_we  = 1'b1;
         end else if (is_realloc || size_ff != '0) begin
            new_cap = size_ff;
            cap_we  = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.search) begin
         if (pop || take_new) cap_mem[gslot] <= '0;
         else if (cap_we)     cap_mem[slot_ff] <= new_cap;
         if (push) stk_mem[top_ff[SW-1:0]] <= slot_ff;
         granted_ff <= (pop || take_new) ? SlotW'(gslot) : '0;
         full_ff    <= rq && !pop && !take_new;
         hit_ff     <= hit_now;
         rh_ff      <= hit_now ? HandleW'(ch_ff[fidx][MIN_HB-1:0]) : '0;
         rcap_ff    <= slot_ok_ff && !rq ? new_cap : '0;
         drop_ff    <= do_ins && !room;
         dh_ff      <= (do_ins && !room) ? HandleW'(h_ff[MIN_HB-1:0]) : '0;
      end
   end

   assign o_granted = granted_ff;
   assign o_full    = full_ff;
   assign o_hit     = hit_ff;
   assign o_rhandle = rh_ff;
   assign o_rcap    = rcap_ff;
   assign o_drop    = drop_ff;
   assign o_dhandle = dh_ff;

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= (CW+1)'(CACHE_DEPTH))
      else $error("cache count overflow");
   assert property (@(posedge clock) disable iff (reset) top_ff <= (SW+1)'(SLOT_COUNT))
      else $error("free stack overflow");
   assert property (@(posedge clock) disable iff (reset) cmd.search |=> !(hit_ff && drop_ff && !is_realloc))
      else $error("drop with hit outside realloc");
endmodule

// ----- hw/rtl/cba_ctrl.sv -----
// Controller: accept, search/commit, hold result until taken.
// Depends on cba_pkg.
module cba_ctrl import cba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_OUT    = 3'b100
   } state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      in_ready    = 1'b0;
      out_valid   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search  = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            out_valid = 1'b1;
            in_ready  = out_ready;
            if (out_ready) begin
               if (in_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = S_SEARCH;
               end else state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset) cmd.capture |=> state_ff == S_SEARCH)
      else $error("capture without search");
   assert property (@(posedge clock) disable iff (reset) state_ff == S_SEARCH |=> out_valid)
      else $error("search without result");
   assert property (@(posedge clock) disable iff (reset) !(cmd.capture && cmd.search))
      else $error("capture and search together");
endmodule

// ----- hw/rtl/caching_block_allocator.sv -----
// Caching block allocator top level: stream ports, controller and datapath.
// Depends on cba_pkg, cba_ctrl, cba_datapath.
//
// Usage: one operation per req transfer (allocate slot, alloc, realloc,
// release); exactly one rsp transfer comes back for each, in order.
// Order: an item is captured into the input registers, the search state
// then loads the result register, and the output state presents it.
// A new req transfer is not taken before the result is taken; the next
// req transfer is taken in the same cycle that the result is taken.
// The search cycle does a parallel compare across all cache cells, a
// priority pick of the first fit and the remove/shift-insert at once.
// Slot capacity and free stack live in memories read in the capture cycle.
// Reset: counts clear, so pool and cache are empty; no clearing pass.
// Stall: while rsp_tready is low the result holds and req_tready stays low.
module caching_block_allocator import cba_pkg::*; #(
   parameter int SLOT_COUNT  = SlotCountDefault,
   parameter int CACHE_DEPTH = CacheDepthDefault,
   parameter int HANDLE_BITS = HandleBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] opcode, [11:2] slot, [43:12] req_size, [91:44] handle, [95:92] zero
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [9:0] granted_slot, [10] slot_pool_full, [11] hit, [59:12] result_handle,
   // [91:60] result_capacity, [92] dropped, [140:93] dropped_handle, [143:141] zero
   output logic [143:0] rsp_tdata
);
   cmd_type            cmd;
   logic [SlotW-1:0]   granted;
   logic               full, hit, drop;
   logic [HandleW-1:0] rh, dh;
   logic [SizeW-1:0]   rcap;

   cba_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd
   );

   cba_datapath #(
      .SLOT_COUNT(SLOT_COUNT), .CACHE_DEPTH(CACHE_DEPTH), .HANDLE_BITS(HANDLE_BITS)
   ) u_dp (
      .clock, .reset, .cmd,
      .in_opcode(req_tdata[1:0]),
      .in_slot(req_tdata[11:2]),
      .in_size(req_tdata[43:12]),
      .in_handle(req_tdata[91:44]),
      .o_granted(granted), .o_full(full), .o_hit(hit), .o_rhandle(rh),
      .o_rcap(rcap), .o_drop(drop), .o_dhandle(dh)
   );

   assign rsp_tdata = {3'b000, dh, drop, rcap, rh, hit, full, granted};
endmodule
